// ===== rtl/cd_subcode_deinterleave_q_crc_defines.svh =====
// assertion macros shared by the subcode deinterleaver modules
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CD_SUBCODE_DEINTERLEAVE_Q_CRC_DEFINES_SVH
`define CD_SUBCODE_DEINTERLEAVE_Q_CRC_DEFINES_SVH

// property checked at every rising clock edge out of reset
`define CDSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CDSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cd_sq_pkg.sv =====
// types, constants and functions of the subcode deinterleaver
// no dependencies
package cd_sq_pkg;

    localparam int BLOCK_BYTES = 96;
    localparam logic [6:0] LAST_POS    = 7'd95;
    localparam logic [6:0] LAST_RW_IDX = 7'd71;
    localparam logic [3:0] Q_CRC_BYTES = 4'd10;
    localparam logic [3:0] Q_CRC_HIGH  = 4'd10;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic KIND_PQ = 1'b0;
    localparam logic KIND_RW = 1'b1;

    localparam logic [2:0] MODE_1       = 3'd0;
    localparam logic [2:0] MODE_2       = 3'd1;
    localparam logic [2:0] MODE_3       = 3'd2;
    localparam logic [2:0] MODE_5       = 3'd3;
    localparam logic [2:0] MODE_ILLEGAL = 3'd4;

    typedef struct packed {
        logic [7:0] sub_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [6:0] byte_index;
        logic [7:0] q_byte;
        logic [7:0] p_byte;
        logic [7:0] rw_byte;
        logic       crc_ok;
        logic [2:0] q_mode;
        logic [3:0] control_nibble;
        logic       block_last;
    } t_result;

    // one group of four raw bytes, as handed from front to back
    typedef struct packed {
        logic            has_pq;
        logic [3:0]      pq_idx;
        logic [7:0]      q_byte;
        logic [7:0]      p_byte;
        logic [6:0]      rw_idx;
        logic [2:0][7:0] rw_bytes;
        logic            last;
        logic            crc_ok;
        logic [2:0]      q_mode;
        logic [3:0]      control_nibble;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PQ,
        ST_RW0,
        ST_RW1,
        ST_RW2
    } t_step;

    // crc-16 ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic logic [2:0] mode_code(input logic [3:0] nib);
        logic [2:0] m;
        unique case (nib)
            4'd1:    m = MODE_1;
            4'd2:    m = MODE_2;
            4'd3:    m = MODE_3;
            4'd5:    m = MODE_5;
            default: m = MODE_ILLEGAL;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/cd_subcode_deinterleave_q_crc.sv =====
// top level of the cd subcode deinterleaver with q channel crc check
// depends on cd_sq_pkg, cd_sq_front, cd_sq_fifo and cd_sq_back
//
// usage
//   input channel (i_valid/o_ready/i_item) takes one raw subcode byte per beat:
//   bit 7 is p, bit 6 is q, bits 5..0 the r-w symbol; frame_start marks byte 0
//   of a 96-byte block and drops any partial block in progress
//   output channel (o_valid/i_ready/o_res) gives one result per beat: every
//   fourth byte yields three packed r-w bytes, every eighth byte first adds the
//   assembled p/q pair; the beat for r-w byte 71 carries block_last, crc_ok,
//   q_mode and control_nibble
//   config channel (i_cfg_valid/o_cfg_ready/i_cfg_data) writes crc_check_enable
//   throughput: one input byte per cycle while the queue has room; the back
//   end emits one result per cycle while i_ready holds, 7 results per 8 bytes,
//   so the stream is sustained at full rate; path: a group's first result
//   passes queue write, job load and output register after its last byte
//   reset: block position, shifters and crc cleared, queue emptied, crc check
//   enabled; no clearing pass
//   receiver stall: the output register holds its beat, the job queue of
//   FIFO_DEPTH groups fills, then o_ready drops until space frees up
module cd_subcode_deinterleave_q_crc import cd_sq_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // byte input
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    // result output
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res,
    // crc_check_enable write port
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    logic r_crc_en;
    logic job_valid, job_ready;
    t_job front_job, queue_job;
    logic q_full, q_empty;
    logic back_ready;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_crc_en <= i_cfg_data;
        end
    end

    // front accepts bytes while the queue has room
    assign job_ready = !q_full;

    cd_sq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_crc_en    (r_crc_en),
        .o_job_valid (job_valid),
        .o_job       (front_job),
        .i_job_ready (job_ready)
    );

    // one entry per group of four bytes
    cd_sq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (back_ready),
        .o_data  (queue_job),
        .o_empty (q_empty)
    );

    // back expands a job into three or four output beats
    cd_sq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .o_job_ready (back_ready),
        .i_job       (queue_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/cd_sq_front.sv =====
// front end: byte position, p/q shifters, q crc and r-w grouping
// depends on cd_sq_pkg
module cd_sq_front import cd_sq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_crc_en,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_ready
);

    logic [6:0]  r_pos, n_pos;
    logic [7:0]  r_q_shift, n_q_shift;
    logic [7:0]  r_p_shift, n_p_shift;
    logic [15:0] r_crc, n_crc;
    logic [17:0] r_rw, n_rw;
    logic [7:0]  r_q_first, n_q_first;
    logic [7:0]  r_q_high, n_q_high;

    logic [6:0]  pos_eff;
    logic        blk_start;
    logic [7:0]  q_base, p_base;
    logic [15:0] crc_base;
    logic [17:0] rw_base;
    logic [5:0]  sym;
    logic        byte_end, grp_end, is_last, accept;
    logic [3:0]  k;
    logic [4:0]  grp;
    logic [15:0] fin;

    assign o_ready = i_job_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // resync or stray position restarts the block
        if (i_item.frame_start || (r_pos >= 7'(BLOCK_BYTES))) begin
            pos_eff = '0;
        end else begin
            pos_eff = r_pos;
        end
        blk_start = (pos_eff == '0);
        q_base    = blk_start ? '0 : r_q_shift;
        p_base    = blk_start ? '0 : r_p_shift;
        crc_base  = blk_start ? '0 : r_crc;
        rw_base   = blk_start ? '0 : r_rw;
        sym       = i_item.sub_byte[5:0];
        byte_end  = (pos_eff[2:0] == 3'd7);
        grp_end   = (pos_eff[1:0] == 2'd3);
        is_last   = (pos_eff == LAST_POS);
        k         = pos_eff[6:3];
        grp       = pos_eff[6:2];

        n_q_shift = {q_base[6:0], i_item.sub_byte[6]};
        n_p_shift = {p_base[6:0], i_item.sub_byte[7]};

        n_crc     = crc_base;
        n_q_first = r_q_first;
        n_q_high  = r_q_high;
        if (byte_end) begin
            if (k < Q_CRC_BYTES) begin
                n_crc = crc16_byte((k == '0) ? 16'h0000 : crc_base, n_q_shift);
            end
            if (k == '0) begin
                n_q_first = n_q_shift;
            end
            if (k == Q_CRC_HIGH) begin
                n_q_high = n_q_shift;
            end
        end

        n_rw  = grp_end ? '0 : {rw_base[11:0], sym};
        n_pos = is_last ? '0 : pos_eff + 7'd1;

        fin = ~crc_base;

        o_job_valid          = i_valid && grp_end;
        o_job.has_pq         = byte_end;
        o_job.pq_idx         = k;
        o_job.q_byte         = n_q_shift;
        o_job.p_byte         = n_p_shift;
        o_job.rw_idx         = {1'b0, grp, 1'b0} + {2'b00, grp};
        // four 6-bit symbols packed into three bytes
        o_job.rw_bytes[0]    = {rw_base[17:12], rw_base[11:10]};
        o_job.rw_bytes[1]    = {rw_base[9:6], rw_base[5:2]};
        o_job.rw_bytes[2]    = {rw_base[1:0], sym};
        o_job.last           = is_last;
        o_job.crc_ok         = !i_crc_en || ((r_q_high == fin[15:8]) && (n_q_shift == fin[7:0]));
        o_job.q_mode         = mode_code(r_q_first[3:0]);
        o_job.control_nibble = r_q_first[7:4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_q_shift <= '0;
            r_p_shift <= '0;
            r_crc     <= '0;
            r_rw      <= '0;
            r_q_first <= '0;
            r_q_high  <= '0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_q_shift <= n_q_shift;
            r_p_shift <= n_p_shift;
            r_crc     <= n_crc;
            r_rw      <= n_rw;
            r_q_first <= n_q_first;
            r_q_high  <= n_q_high;
        end
    end

endmodule

// ===== rtl/cd_sq_fifo.sv =====
// short job queue between front and back
// depends on cd_sq_pkg and the assertion macro header
`include "cd_subcode_deinterleave_q_crc_defines.svh"
module cd_sq_fifo import cd_sq_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `CDSQ_ASSERT(a_count_bound, r_count <= CNT_FULL, "job queue count above depth")
    `CDSQ_ASSERT_NEXT(a_pop_drains, do_pop && !do_push, r_count == $past(r_count) - CNT_W'(1), "pop did not drain")

endmodule

// ===== rtl/cd_sq_back.sv =====
// back end: expands each job into its p/q and r-w result beats
// depends on cd_sq_pkg and the assertion macro header
`include "cd_subcode_deinterleave_q_crc_defines.svh"
module cd_sq_back import cd_sq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    output logic    o_job_ready,
    input  t_job    i_job,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_step   r_state, n_state;
    t_job    r_job;
    logic    r_out_valid;
    t_result r_out, res;
    logic    out_load, is_final, pop;
    t_step   first_step;

    assign out_load    = (r_state != ST_IDLE) && (!r_out_valid || i_ready);
    assign is_final    = (r_state == ST_RW2);
    assign o_job_ready = (r_state == ST_IDLE) || (out_load && is_final);
    assign pop         = i_job_valid && o_job_ready;
    assign first_step  = i_job.has_pq ? ST_PQ : ST_RW0;
    assign o_valid     = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        res     = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    n_state = first_step;
                end
            end
            ST_PQ: begin
                res.kind       = KIND_PQ;
                res.byte_index = {3'b000, r_job.pq_idx};
                res.q_byte     = r_job.q_byte;
                res.p_byte     = r_job.p_byte;
                if (out_load) begin
                    n_state = ST_RW0;
                end
            end
            ST_RW0: begin
                res.kind       = KIND_RW;
                res.byte_index = r_job.rw_idx;
                res.rw_byte    = r_job.rw_bytes[0];
                if (out_load) begin
                    n_state = ST_RW1;
                end
            end
            ST_RW1: begin
                res.kind       = KIND_RW;
                res.byte_index = r_job.rw_idx + 7'd1;
                res.rw_byte    = r_job.rw_bytes[1];
                if (out_load) begin
                    n_state = ST_RW2;
                end
            end
            ST_RW2: begin
                res.kind       = KIND_RW;
                res.byte_index = r_job.rw_idx + 7'd2;
                res.rw_byte    = r_job.rw_bytes[2];
                if (r_job.last) begin
                    res.crc_ok         = r_job.crc_ok;
                    res.q_mode         = r_job.q_mode;
                    res.control_nibble = r_job.control_nibble;
                    res.block_last     = 1'b1;
                end
                if (out_load) begin
                    n_state = pop ? first_step : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
        end
        if (out_load) begin
            r_out <= res;
        end
    end

    `CDSQ_ASSERT(a_pq_has_pair, (r_state == ST_PQ) |-> r_job.has_pq, "p/q beat for a job without a pair")
    `CDSQ_ASSERT(a_last_index, (r_out_valid && r_out.block_last) |-> ((r_out.kind == KIND_RW) && (r_out.byte_index == LAST_RW_IDX)), "block end on wrong beat")

endmodule
